// File: sv/mpsm_pkg.sv
// shared types, codes and defaults for the multi-pattern string matcher
// no dependencies; used by the top level, mpsm_ctrl and mpsm_dp
`default_nettype none
package mpsm_pkg;

    localparam int MAX_NODES_DEF = 256;
    localparam int ALPHABET_DEF  = 26;

    // func codes of an input item
    localparam logic [1:0] FN_PAT   = 2'd0;
    localparam logic [1:0] FN_BUILD = 2'd1;
    localparam logic [1:0] FN_TEXT  = 2'd2;
    localparam logic [1:0] FN_CLEAR = 2'd3;

    // result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_NOBUILD = 2'd2;

    // controller states, also the datapath operation codes
    localparam logic [4:0] OP_CLR    = 5'd0;
    localparam logic [4:0] OP_IDLE   = 5'd1;
    localparam logic [4:0] OP_DISP   = 5'd2;
    localparam logic [4:0] OP_P_RD   = 5'd3;
    localparam logic [4:0] OP_P_CHK  = 5'd4;
    localparam logic [4:0] OP_P_ZERO = 5'd5;
    localparam logic [4:0] OP_P_END  = 5'd6;
    localparam logic [4:0] OP_T_RD   = 5'd7;
    localparam logic [4:0] OP_T_MK   = 5'd8;
    localparam logic [4:0] OP_T_CHK  = 5'd9;
    localparam logic [4:0] OP_A_RD   = 5'd10;
    localparam logic [4:0] OP_A_CHK  = 5'd11;
    localparam logic [4:0] OP_B_NODE = 5'd12;
    localparam logic [4:0] OP_B_U    = 5'd13;
    localparam logic [4:0] OP_B_F    = 5'd14;
    localparam logic [4:0] OP_B_RV   = 5'd15;
    localparam logic [4:0] OP_B_RT   = 5'd16;
    localparam logic [4:0] OP_B_DEC  = 5'd17;
    localparam logic [4:0] OP_B_MT   = 5'd18;
    localparam logic [4:0] OP_B_MV   = 5'd19;
    localparam logic [4:0] OP_FIN    = 5'd20;

    typedef struct packed {
        logic [4:0] op;
    } t_cmd;

    typedef struct packed {
        logic [1:0] func;
        logic       last;
        logic       built;
        logic       spoiled;
        logic       bad;
        logic       child_zero;
        logic       full;
        logic       q_empty;
        logic       row_done;
        logic       v_zero;
    } t_stat;

endpackage
`default_nettype wire

// File: sv/multi_pattern_string_matcher.sv
// top level of the multi-pattern string matcher: controller, datapath, output register
// depends on mpsm_pkg, mpsm_ctrl, mpsm_dp
//
// lowercase aho-corasick matcher. pattern items (tuser 0) insert letters into a
// trie; tlast ends a pattern. a build item (tuser 1) computes failure links
// breadth-first, fills every missing goto edge and carries match marks down the
// failure links. text items (tuser 2) then step the scan state; every item returns
// one result: a sticky found bit and a status (0 ok, 1 node table full and letter
// dropped, 2 text before build). clear (tuser 3) drops all patterns. one item is
// worked at a time: a text letter's result is set by the goto read followed by the
// match-mark read through registered-read memories, and the next item is taken once
// the result is in the output register; a pattern letter that opens a new node also
// zeroes its goto row; build walks the root row, then each queued node letter by
// letter. after reset and after a clear, a pass over the root row zeroes it, with
// s_tready low.
// a waiting result sits in the output register while the next item is accepted.
`default_nettype none
module multi_pattern_string_matcher #(
    parameter int MaxNodes = mpsm_pkg::MAX_NODES_DEF,
    parameter int Alphabet = mpsm_pkg::ALPHABET_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_s_tvalid,
    output logic            o_s_tready,
    input  wire logic [7:0] i_s_tdata,   // [4:0] letter, [7:5] zero
    input  wire logic       i_s_tlast,   // last
    input  wire logic [1:0] i_s_tuser,   // [1:0] func
    output logic            o_m_tvalid,
    input  wire logic       i_m_tready,
    output logic [7:0]      o_m_tdata    // [0] found, [2:1] status, [7:3] zero
);
    mpsm_pkg::t_cmd  w_cmd;
    mpsm_pkg::t_stat w_stat;
    logic            w_in_fire, w_out_free, w_res_found;
    logic [1:0]      w_res_status;
    logic            r_m_tvalid;
    logic [7:0]      r_m_tdata;

    // accept only while the controller waits for work
    assign o_s_tready = (w_cmd.op == mpsm_pkg::OP_IDLE);
    assign w_in_fire  = i_s_tvalid && o_s_tready;
    // output register can take a result when empty or being drained
    assign w_out_free = !r_m_tvalid || i_m_tready;
    assign o_m_tvalid = r_m_tvalid;
    assign o_m_tdata  = r_m_tdata;

    mpsm_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_fire(w_in_fire),
        .i_out_free(w_out_free), .i_stat(w_stat), .o_cmd(w_cmd)
    );

    mpsm_dp #(.MaxNodes(MaxNodes), .Alphabet(Alphabet)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_fire(w_in_fire),
        .i_func(i_s_tuser), .i_letter(i_s_tdata[4:0]), .i_last(i_s_tlast),
        .i_cmd(w_cmd), .o_stat(w_stat),
        .o_res_found(w_res_found), .o_res_status(w_res_status)
    );

    // result register, loaded as the item finishes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_tvalid <= 1'b0;
        end else if (w_cmd.op == mpsm_pkg::OP_FIN && w_out_free) begin
            r_m_tvalid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_cmd.op == mpsm_pkg::OP_FIN && w_out_free) begin
            r_m_tdata <= {5'd0, w_res_status, w_res_found};
        end
    end
endmodule
`default_nettype wire

// File: sv/mpsm_ram.sv
// generic single write port ram with registered read
// no dependencies
`default_nettype none
module mpsm_ram #(
    parameter int Width = 8,
    parameter int Depth = 256,
    localparam int AW = (Depth > 1) ? $clog2(Depth) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [Width-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [Width-1:0] o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// File: sv/mpsm_dp.sv
// datapath: trie and automaton memories, cursors, counters and result fields
// depends on mpsm_pkg and mpsm_ram
`default_nettype none
module mpsm_dp #(
    parameter int MaxNodes = mpsm_pkg::MAX_NODES_DEF,
    parameter int Alphabet = mpsm_pkg::ALPHABET_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_fire,
    input  wire logic [1:0]     i_func,
    input  wire logic [4:0]     i_letter,
    input  wire logic           i_last,
    input  wire mpsm_pkg::t_cmd i_cmd,
    output mpsm_pkg::t_stat     o_stat,
    output logic                o_res_found,
    output logic [1:0]          o_res_status
);
    localparam int NW  = $clog2(MaxNodes);
    localparam int NCW = NW + 1;
    localparam int AW  = $clog2(MaxNodes * Alphabet);
    localparam int CW  = $clog2(Alphabet);
    localparam int GD  = MaxNodes * Alphabet;

    logic [1:0]     r_func;
    logic [4:0]     r_letter;
    logic           r_last;
    logic [NCW-1:0] r_node_count;
    logic [NW-1:0]  r_cursor, r_scan, r_v;
    logic           r_found, r_built, r_spoiled, r_mt;
    logic [CW-1:0]  r_cidx;
    logic [NCW-1:0] r_head, r_tail;
    logic [AW-1:0]  r_addr, r_base_u, r_base_f;
    logic           r_res;
    logic [1:0]     r_status;

    logic [NW-1:0] w_goto_q, w_fail_q, w_queue_q;
    logic          w_mark_q;

    logic          g_we;
    logic [AW-1:0] g_wa, g_ra;
    logic [NW-1:0] g_wd;
    logic          m_we, m_wd;
    logic [NW-1:0] m_wa, m_ra;
    logic          f_we;
    logic [NW-1:0] f_wa, f_wd, f_ra;
    logic          q_we;
    logic [NW-1:0] q_wa, q_wd, q_ra;

    logic          w_bad;
    logic [NW-1:0] w_new;
    logic [NW-1:0] w_ns;

    assign w_bad = 9'(r_letter) >= 9'(Alphabet);
    assign w_new = r_node_count[NW-1:0];
    assign w_ns  = w_bad ? '0 : w_goto_q;

    assign o_stat.func       = r_func;
    assign o_stat.last       = r_last;
    assign o_stat.built      = r_built;
    assign o_stat.spoiled    = r_spoiled;
    assign o_stat.bad        = w_bad;
    assign o_stat.child_zero = (w_goto_q == '0);
    assign o_stat.full       = (r_node_count == NCW'(MaxNodes));
    assign o_stat.q_empty    = (r_head == r_tail);
    assign o_stat.row_done   = (r_cidx == CW'(Alphabet - 1));
    assign o_stat.v_zero     = (r_v == '0);
    assign o_res_found       = r_res;
    assign o_res_status      = r_status;

    // memory port steering
    always_comb begin
        g_we = 1'b0; g_wa = r_addr; g_wd = '0; g_ra = r_addr;
        m_we = 1'b0; m_wa = '0; m_wd = 1'b0; m_ra = '0;
        f_we = 1'b0; f_wa = w_goto_q; f_wd = '0; f_ra = w_queue_q;
        q_we = 1'b0; q_wa = r_tail[NW-1:0]; q_wd = w_goto_q; q_ra = r_head[NW-1:0];
        unique case (i_cmd.op)
            mpsm_pkg::OP_CLR: begin
                g_we = 1'b1;
                g_wa = AW'(r_cidx);
                m_we = (r_cidx == '0);
            end
            mpsm_pkg::OP_P_CHK: begin
                if (w_goto_q == '0 && r_node_count != NCW'(MaxNodes)) begin
                    g_we = 1'b1;
                    g_wd = w_new;
                    m_we = 1'b1;
                    m_wa = w_new;
                end
            end
            mpsm_pkg::OP_P_ZERO: begin
                g_we = 1'b1;
                g_wa = r_addr + AW'(r_cidx);
            end
            mpsm_pkg::OP_P_END: begin
                m_we = r_last && !r_spoiled && (r_cursor != '0);
                m_wa = r_cursor;
                m_wd = 1'b1;
            end
            mpsm_pkg::OP_T_MK: m_ra = w_ns;
            mpsm_pkg::OP_A_RD: g_ra = AW'(r_cidx);
            mpsm_pkg::OP_A_CHK: begin
                f_we = (w_goto_q != '0);
                q_we = (w_goto_q != '0);
            end
            mpsm_pkg::OP_B_RV: g_ra = r_base_u + AW'(r_cidx);
            mpsm_pkg::OP_B_RT: g_ra = r_base_f + AW'(r_cidx);
            mpsm_pkg::OP_B_DEC: begin
                m_ra = w_goto_q;
                if (r_v == '0) begin
                    // missing edge takes the failure target's edge
                    g_we = 1'b1;
                    g_wa = r_base_u + AW'(r_cidx);
                    g_wd = w_goto_q;
                end else begin
                    f_we = 1'b1;
                    f_wa = r_v;
                    f_wd = w_goto_q;
                    q_we = 1'b1;
                    q_wd = r_v;
                end
            end
            mpsm_pkg::OP_B_MT: m_ra = r_v;
            mpsm_pkg::OP_B_MV: begin
                m_we = 1'b1;
                m_wa = r_v;
                m_wd = w_mark_q | r_mt;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= NCW'(1);
            r_cursor     <= '0;
            r_scan       <= '0;
            r_found      <= 1'b0;
            r_built      <= 1'b0;
            r_spoiled    <= 1'b0;
            r_cidx       <= '0;
            r_head       <= '0;
            r_tail       <= '0;
        end else begin
            unique case (i_cmd.op)
                mpsm_pkg::OP_CLR: begin
                    r_cidx <= o_stat.row_done ? '0 : r_cidx + CW'(1);
                end
                mpsm_pkg::OP_IDLE: begin
                    if (i_in_fire) begin
                        r_func   <= i_func;
                        r_letter <= i_letter;
                        r_last   <= i_last;
                    end
                end
                mpsm_pkg::OP_DISP: begin
                    r_res    <= r_found;
                    r_status <= (r_func == mpsm_pkg::FN_TEXT && !r_built)
                                ? mpsm_pkg::ST_NOBUILD : mpsm_pkg::ST_OK;
                    r_cidx   <= '0;
                    r_head   <= '0;
                    r_tail   <= '0;
                    if (r_func == mpsm_pkg::FN_TEXT) begin
                        r_addr <= AW'(r_scan) * AW'(Alphabet) + AW'(r_letter);
                    end else begin
                        r_addr <= AW'(r_cursor) * AW'(Alphabet) + AW'(r_letter);
                    end
                    if (r_func == mpsm_pkg::FN_PAT && !r_built && w_bad) begin
                        r_spoiled <= 1'b1;
                    end
                    if (r_func == mpsm_pkg::FN_CLEAR) begin
                        r_res        <= 1'b0;
                        r_node_count <= NCW'(1);
                        r_cursor     <= '0;
                        r_scan       <= '0;
                        r_found      <= 1'b0;
                        r_built      <= 1'b0;
                        r_spoiled    <= 1'b0;
                    end
                end
                mpsm_pkg::OP_P_CHK: begin
                    if (w_goto_q != '0) begin
                        r_cursor <= w_goto_q;
                    end else if (o_stat.full) begin
                        r_spoiled <= 1'b1;
                        r_status  <= mpsm_pkg::ST_FULL;
                    end else begin
                        r_cursor     <= w_new;
                        r_node_count <= r_node_count + NCW'(1);
                        r_addr       <= AW'(w_new) * AW'(Alphabet);
                    end
                end
                mpsm_pkg::OP_P_ZERO: begin
                    r_cidx <= o_stat.row_done ? '0 : r_cidx + CW'(1);
                end
                mpsm_pkg::OP_P_END: begin
                    if (r_last) begin
                        r_cursor  <= '0;
                        r_spoiled <= 1'b0;
                    end
                end
                mpsm_pkg::OP_T_MK: r_scan <= w_ns;
                mpsm_pkg::OP_T_CHK: begin
                    r_res <= r_found | w_mark_q;
                    if (r_last) begin
                        r_scan  <= '0;
                        r_found <= 1'b0;
                    end else begin
                        r_found <= r_found | w_mark_q;
                    end
                end
                mpsm_pkg::OP_A_CHK: begin
                    if (w_goto_q != '0) begin
                        r_tail <= r_tail + NCW'(1);
                    end
                    r_cidx <= o_stat.row_done ? '0 : r_cidx + CW'(1);
                end
                mpsm_pkg::OP_B_NODE: begin
                    if (o_stat.q_empty) begin
                        r_built   <= 1'b1;
                        r_cursor  <= '0;
                        r_spoiled <= 1'b0;
                    end else begin
                        r_head <= r_head + NCW'(1);
                    end
                end
                mpsm_pkg::OP_B_U: r_base_u <= AW'(w_queue_q) * AW'(Alphabet);
                mpsm_pkg::OP_B_F: begin
                    r_base_f <= AW'(w_fail_q) * AW'(Alphabet);
                    r_cidx   <= '0;
                end
                mpsm_pkg::OP_B_RT: r_v <= w_goto_q;
                mpsm_pkg::OP_B_DEC: begin
                    if (r_v == '0) begin
                        r_cidx <= o_stat.row_done ? '0 : r_cidx + CW'(1);
                    end else begin
                        r_tail <= r_tail + NCW'(1);
                    end
                end
                mpsm_pkg::OP_B_MT: r_mt <= w_mark_q;
                mpsm_pkg::OP_B_MV: begin
                    r_cidx <= o_stat.row_done ? '0 : r_cidx + CW'(1);
                end
                default: ;
            endcase
        end
    end

    mpsm_ram #(.Width(NW), .Depth(GD)) u_goto (
        .i_clk(i_clk), .i_we(g_we), .i_waddr(g_wa), .i_wdata(g_wd),
        .i_raddr(g_ra), .o_rdata(w_goto_q)
    );
    mpsm_ram #(.Width(1), .Depth(MaxNodes)) u_mark (
        .i_clk(i_clk), .i_we(m_we), .i_waddr(m_wa), .i_wdata(m_wd),
        .i_raddr(m_ra), .o_rdata(w_mark_q)
    );
    mpsm_ram #(.Width(NW), .Depth(MaxNodes)) u_fail (
        .i_clk(i_clk), .i_we(f_we), .i_waddr(f_wa), .i_wdata(f_wd),
        .i_raddr(f_ra), .o_rdata(w_fail_q)
    );
    mpsm_ram #(.Width(NW), .Depth(MaxNodes)) u_queue (
        .i_clk(i_clk), .i_we(q_we), .i_waddr(q_wa), .i_wdata(q_wd),
        .i_raddr(q_ra), .o_rdata(w_queue_q)
    );
endmodule
`default_nettype wire

// File: sv/mpsm_ctrl.sv
// controller: sequences insert, build, scan and clear over the datapath
// depends on mpsm_pkg
`default_nettype none
module mpsm_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_fire,
    input  wire logic            i_out_free,
    input  wire mpsm_pkg::t_stat i_stat,
    output mpsm_pkg::t_cmd       o_cmd
);
    logic [4:0] r_state, n_state;
    logic       r_clr_ret, n_clr_ret;

    assign o_cmd.op = r_state;

    always_comb begin
        n_state   = r_state;
        n_clr_ret = r_clr_ret;
        unique case (r_state)
            mpsm_pkg::OP_CLR: begin
                if (i_stat.row_done) begin
                    n_state = r_clr_ret ? mpsm_pkg::OP_FIN : mpsm_pkg::OP_IDLE;
                end
            end
            mpsm_pkg::OP_IDLE: if (i_in_fire) n_state = mpsm_pkg::OP_DISP;
            mpsm_pkg::OP_DISP: begin
                unique case (i_stat.func)
                    mpsm_pkg::FN_PAT: begin
                        if (i_stat.built) n_state = mpsm_pkg::OP_FIN;
                        else if (i_stat.spoiled || i_stat.bad) n_state = mpsm_pkg::OP_P_END;
                        else n_state = mpsm_pkg::OP_P_RD;
                    end
                    mpsm_pkg::FN_BUILD: begin
                        n_state = i_stat.built ? mpsm_pkg::OP_FIN : mpsm_pkg::OP_A_RD;
                    end
                    mpsm_pkg::FN_TEXT: begin
                        n_state = i_stat.built ? mpsm_pkg::OP_T_RD : mpsm_pkg::OP_FIN;
                    end
                    default: begin
                        n_state   = mpsm_pkg::OP_CLR;
                        n_clr_ret = 1'b1;
                    end
                endcase
            end
            mpsm_pkg::OP_P_RD: n_state = mpsm_pkg::OP_P_CHK;
            mpsm_pkg::OP_P_CHK: begin
                n_state = (i_stat.child_zero && !i_stat.full)
                          ? mpsm_pkg::OP_P_ZERO : mpsm_pkg::OP_P_END;
            end
            mpsm_pkg::OP_P_ZERO: if (i_stat.row_done) n_state = mpsm_pkg::OP_P_END;
            mpsm_pkg::OP_P_END: n_state = mpsm_pkg::OP_FIN;
            mpsm_pkg::OP_T_RD:  n_state = mpsm_pkg::OP_T_MK;
            mpsm_pkg::OP_T_MK:  n_state = mpsm_pkg::OP_T_CHK;
            mpsm_pkg::OP_T_CHK: n_state = mpsm_pkg::OP_FIN;
            mpsm_pkg::OP_A_RD:  n_state = mpsm_pkg::OP_A_CHK;
            mpsm_pkg::OP_A_CHK: begin
                n_state = i_stat.row_done ? mpsm_pkg::OP_B_NODE : mpsm_pkg::OP_A_RD;
            end
            mpsm_pkg::OP_B_NODE: begin
                n_state = i_stat.q_empty ? mpsm_pkg::OP_FIN : mpsm_pkg::OP_B_U;
            end
            mpsm_pkg::OP_B_U:  n_state = mpsm_pkg::OP_B_F;
            mpsm_pkg::OP_B_F:  n_state = mpsm_pkg::OP_B_RV;
            mpsm_pkg::OP_B_RV: n_state = mpsm_pkg::OP_B_RT;
            mpsm_pkg::OP_B_RT: n_state = mpsm_pkg::OP_B_DEC;
            mpsm_pkg::OP_B_DEC: begin
                if (!i_stat.v_zero) n_state = mpsm_pkg::OP_B_MT;
                else if (i_stat.row_done) n_state = mpsm_pkg::OP_B_NODE;
                else n_state = mpsm_pkg::OP_B_RV;
            end
            mpsm_pkg::OP_B_MT: n_state = mpsm_pkg::OP_B_MV;
            mpsm_pkg::OP_B_MV: begin
                n_state = i_stat.row_done ? mpsm_pkg::OP_B_NODE : mpsm_pkg::OP_B_RV;
            end
            mpsm_pkg::OP_FIN: if (i_out_free) n_state = mpsm_pkg::OP_IDLE;
            default: n_state = mpsm_pkg::OP_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= mpsm_pkg::OP_CLR;
            r_clr_ret <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clr_ret <= n_clr_ret;
        end
    end
endmodule
`default_nettype wire

// File: sv/mpsm_chk.sv
// port-level checker for the multi-pattern string matcher, bound to the top level
// depends on multi_pattern_string_matcher
`default_nettype none
module mpsm_chk (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_s_tvalid,
    input wire logic       o_s_tready,
    input wire logic       o_m_tvalid,
    input wire logic       i_m_tready,
    input wire logic [7:0] o_m_tdata
);
    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result changed while stalled");

    // status code three is never produced
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[2:1] != 2'd3)
        else $error("bad status code");

    // one item at a time: no accept right after an accept
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("ready right after accept");

    // padding bits stay zero
    a_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[7:3] == 5'd0)
        else $error("result padding not zero");
endmodule

bind multi_pattern_string_matcher mpsm_chk u_mpsm_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_s_tvalid(i_s_tvalid),
    .o_s_tready(o_s_tready), .o_m_tvalid(o_m_tvalid),
    .i_m_tready(i_m_tready), .o_m_tdata(o_m_tdata)
);
`default_nettype wire

// File: tb/sv/multi_pattern_string_matcher_test.sv
// self-checking testbench for the multi-pattern string matcher
// depends on mpsm_pkg and multi_pattern_string_matcher; a scoreboard class keeps its own
// automaton, predicts one result per accepted item and checks the results in order
`timescale 1ns / 1ps
`default_nettype none

typedef struct {
    bit         found;
    logic [1:0] status;
} t_match_result;

class match_scoreboard;
    localparam int NODES = mpsm_pkg::MAX_NODES_DEF;
    localparam int ALPH  = mpsm_pkg::ALPHABET_DEF;

    logic [7:0]    goto_tab[NODES*ALPH];
    logic [7:0]    fail_of[NODES];
    bit            mark[NODES];
    int            node_total;
    int            cursor;
    int            scan;
    bit            found_flag;
    bit            built;
    bit            spoiled;
    t_match_result due[$];
    int            errors;

    function new();
        foreach (goto_tab[i]) goto_tab[i] = '0;
        foreach (fail_of[i]) fail_of[i] = '0;
        errors = 0;
        clear_patterns();
    endfunction

    function void clear_patterns();
        foreach (mark[i]) mark[i] = 0;
        for (int c = 0; c < ALPH; c++) goto_tab[c] = '0;
        node_total = 1;
        cursor     = 0;
        scan       = 0;
        found_flag = 0;
        built      = 0;
        spoiled    = 0;
    endfunction

    function logic [1:0] add_letter(int l, bit t);
        logic [1:0] st;
        int         child;
        st = mpsm_pkg::ST_OK;
        if (!spoiled) begin
            if (l >= ALPH) begin
                spoiled = 1;
            end else begin
                child = goto_tab[cursor*ALPH + l];
                if (child == 0) begin
                    if (node_total >= NODES) begin
                        spoiled = 1;
                        st = mpsm_pkg::ST_FULL;
                    end else begin
                        child = node_total;
                        node_total++;
                        for (int c = 0; c < ALPH; c++) goto_tab[child*ALPH + c] = '0;
                        mark[child] = 0;
                        goto_tab[cursor*ALPH + l] = child[7:0];
                    end
                end
                if (!spoiled) cursor = child;
            end
        end
        if (t) begin
            if (!spoiled && cursor != 0) mark[cursor] = 1;
            cursor  = 0;
            spoiled = 0;
        end
        return st;
    endfunction

    // breadth-first failure links, goto completion and mark propagation
    function void build_automaton();
        int bq[$];
        int u, f, v, t;
        for (int c = 0; c < ALPH; c++) begin
            v = goto_tab[c];
            if (v != 0) begin
                fail_of[v] = '0;
                bq.insert(bq.size(), v);
            end
        end
        while (bq.size() != 0) begin
            u = bq.pop_front();
            f = fail_of[u];
            for (int c = 0; c < ALPH; c++) begin
                v = goto_tab[u*ALPH + c];
                t = goto_tab[f*ALPH + c];
                if (v != 0) begin
                    fail_of[v] = t[7:0];
                    mark[v] = mark[v] | mark[t];
                    bq.insert(bq.size(), v);
                end else begin
                    goto_tab[u*ALPH + c] = t[7:0];
                end
            end
        end
        cursor  = 0;
        spoiled = 0;
        built   = 1;
    endfunction

    function void note_item(logic [1:0] f, int l, bit t);
        t_match_result r;
        r.status = mpsm_pkg::ST_OK;
        case (f)
            mpsm_pkg::FN_PAT: begin
                if (!built) r.status = add_letter(l, t);
            end
            mpsm_pkg::FN_BUILD: begin
                if (!built) build_automaton();
            end
            mpsm_pkg::FN_TEXT: begin
                if (!built) begin
                    r.status = mpsm_pkg::ST_NOBUILD;
                end else begin
                    scan = (l < ALPH) ? int'(goto_tab[scan*ALPH + l]) : 0;
                    if (mark[scan]) found_flag = 1;
                end
            end
            default: clear_patterns();
        endcase
        r.found = found_flag;
        if (f == mpsm_pkg::FN_TEXT && built && t) begin
            scan       = 0;
            found_flag = 0;
        end
        due.insert(due.size(), r);
    endfunction

    function void check_result(logic [7:0] d);
        t_match_result r;
        if (due.size() == 0) begin
            $error("result 0x%02h with no item waiting", d);
            errors++;
            return;
        end
        r = due.pop_front();
        if (d[0] !== r.found) begin
            $error("found: expected %0d, actual %0d", r.found, d[0]);
            errors++;
        end
        if (d[2:1] !== r.status) begin
            $error("status: expected %0d, actual %0d", r.status, d[2:1]);
            errors++;
        end
        if (d[7:3] !== 5'd0) begin
            $error("pad: expected 0, actual %0d", d[7:3]);
            errors++;
        end
    endfunction
endclass

module multi_pattern_string_matcher_test;
    localparam int STALL_LIMIT = 150000;   // well above the slowest build with a full table
    localparam int HOLD_CYCLES = 400;      // long receiver hold-off

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_s_tvalid = 1'b0;
    logic [7:0] i_s_tdata = '0;            // [4:0] letter, [7:5] zero
    logic       i_s_tlast = 1'b0;          // last
    logic [1:0] i_s_tuser = mpsm_pkg::FN_PAT;  // [1:0] func
    logic       i_m_tready = 1'b0;
    logic       o_s_tready;
    logic       o_m_tvalid;
    logic [7:0] o_m_tdata;                 // [0] found, [2:1] status, [7:3] zero

    match_scoreboard sb = new();
    int  items_sent = 0;
    int  results_seen = 0;
    int  quiet_cycles = 0;
    bit  calm = 0;       // no idling on either side while set
    bit  held = 0;

    multi_pattern_string_matcher i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // offer one item, with random idle cycles ahead of it, and note it when it is taken
    task automatic send_item(logic [1:0] f, int l, bit t);
        while (!calm && $urandom_range(0, 99) < 20) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= f;
        i_s_tdata  <= {3'b000, 5'(l)};
        i_s_tlast  <= t;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        sb.note_item(f, l, t);
        items_sent++;
        @(negedge i_clk);
    endtask

    // letters mostly from a narrow range so that patterns share prefixes and suffixes
    function automatic int pick_letter();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(0, 3);
        if (r < 94) return $urandom_range(0, 25);
        return $urandom_range(26, 31);
    endfunction

    task automatic send_word(logic [1:0] f, int len);
        for (int i = 0; i < len; i++) send_item(f, pick_letter(), i == len - 1);
    endtask

    // receiver: random stalls, one long hold-off once the run is under way
    initial begin
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (!held && results_seen > 700) begin
                held = 1;
                i_m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            i_m_tready <= calm || ($urandom_range(0, 99) >= 20);
        end
    end

    always @(posedge i_clk) begin
        if (o_m_tvalid && i_m_tready) begin
            sb.check_result(o_m_tdata);
            results_seen++;
        end
    end

    // watchdog on cycles with no handshake on either side
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("** multi_pattern_string_matcher: FAILED **");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int episode;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: text before build, extremes, suffix patterns, special cases
        send_item(mpsm_pkg::FN_TEXT, 0, 1'b1);
        send_item(mpsm_pkg::FN_PAT, 0, 1'b1);              // one-letter pattern
        send_item(mpsm_pkg::FN_PAT, 7, 1'b0);              // "he"
        send_item(mpsm_pkg::FN_PAT, 4, 1'b1);
        send_item(mpsm_pkg::FN_PAT, 18, 1'b0);             // "s", an out-of-range letter, "z": a spoiled pattern
        send_item(mpsm_pkg::FN_PAT, 31, 1'b0);
        send_item(mpsm_pkg::FN_PAT, 25, 1'b1);
        send_item(mpsm_pkg::FN_PAT, 25, 1'b0);             // "z" with no tlast, abandoned by build
        send_item(mpsm_pkg::FN_BUILD, 0, 1'b0);
        send_item(mpsm_pkg::FN_BUILD, 31, 1'b1);           // repeated build
        send_item(mpsm_pkg::FN_PAT, 3, 1'b1);              // pattern after build
        send_item(mpsm_pkg::FN_TEXT, 18, 1'b0);            // "she" finds "he" as a suffix
        send_item(mpsm_pkg::FN_TEXT, 7, 1'b0);
        send_item(mpsm_pkg::FN_TEXT, 4, 1'b0);
        send_item(mpsm_pkg::FN_TEXT, 25, 1'b1);
        send_item(mpsm_pkg::FN_TEXT, 25, 1'b0);            // "z", out of range, then "a"
        send_item(mpsm_pkg::FN_TEXT, 30, 1'b0);
        send_item(mpsm_pkg::FN_TEXT, 0, 1'b1);
        send_item(mpsm_pkg::FN_TEXT, 25, 1'b1);
        send_item(mpsm_pkg::FN_CLEAR, 31, 1'b1);
        send_item(mpsm_pkg::FN_TEXT, 0, 1'b1);
        send_item(mpsm_pkg::FN_PAT, 31, 1'b1);
        send_item(mpsm_pkg::FN_BUILD, 0, 1'b0);
        send_item(mpsm_pkg::FN_TEXT, 0, 1'b1);

        // random episodes: patterns, build, texts; two episodes fill the node table
        episode = 0;
        while (items_sent < 1800) begin
            calm = (items_sent > 900 && items_sent < 1200);
            send_item(mpsm_pkg::FN_CLEAR, $urandom_range(0, 31), $urandom_range(0, 1));
            if (episode == 2 || episode == 25) begin
                while (sb.node_total < 256 || $urandom_range(0, 3) != 0)
                    send_word(mpsm_pkg::FN_PAT, $urandom_range(8, 14));
                send_item(mpsm_pkg::FN_PAT, $urandom_range(0, 25), 1'b1);
            end else begin
                repeat ($urandom_range(1, 6))
                    send_word(mpsm_pkg::FN_PAT, $urandom_range(1, 4));
            end
            if ($urandom_range(0, 9) == 0) send_item(mpsm_pkg::FN_TEXT, pick_letter(), 1'b1);
            if ($urandom_range(0, 9) == 0) send_item(mpsm_pkg::FN_PAT, pick_letter(), 1'b0);
            send_item(mpsm_pkg::FN_BUILD, $urandom_range(0, 31), $urandom_range(0, 1));
            if ($urandom_range(0, 9) == 0) send_item(mpsm_pkg::FN_BUILD, pick_letter(), 1'b0);
            if ($urandom_range(0, 9) == 0) send_item(mpsm_pkg::FN_PAT, pick_letter(), 1'b1);
            repeat ($urandom_range(3, 10)) send_word(mpsm_pkg::FN_TEXT, $urandom_range(1, 8));
            episode++;
        end
        i_s_tvalid <= 1'b0;

        while (sb.due.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("** multi_pattern_string_matcher: PASSED **");
        end else begin
            $display("** multi_pattern_string_matcher: FAILED **");
        end
        $finish;
    end
endmodule
`default_nettype wire

// File: sim.f
sv/mpsm_pkg.sv
sv/mpsm_ram.sv
sv/mpsm_dp.sv
sv/mpsm_ctrl.sv
sv/multi_pattern_string_matcher.sv
sv/mpsm_chk.sv
tb/sv/multi_pattern_string_matcher_test.sv
